// ----- sv/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// COBS frame decoder package
// Transfer types and constants shared by the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

  localparam logic [7:0]  FullCode = 8'hFF;
  localparam logic [15:0] MaxCount = 16'hFFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_frame;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        frame_error;
    logic        frame_last;
    logic [15:0] decoded_length;
  } out_t;

endpackage

`default_nettype wire

// ----- sv/cobs_frame_decoder_core.sv -----
// ----------------------------------------------------------------------------
// COBS frame decoder core
// Decodes one COBS-encoded byte per transfer into zero or one result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one encoded
//   byte per transfer, with end_of_frame set on the final byte of a frame.
//   Output channel (out_valid_o / out_stall_i / out_data_o) carries decoded
//   bytes; the last result of each frame has frame_last set and reports
//   frame_error and decoded_length (0 on error). Code bytes that emit
//   nothing and bytes dropped after an error produce no output transfer
//   unless they end a frame. Results are registered in a two-entry output
//   stage (output register plus skid register), so the input keeps flowing
//   after the receiver stalls; in_stall_o rises only once the skid register
//   holds a result. Throughput: one input transfer per cycle while
//   in_stall_o is low, set by the single decode stage that updates the
//   block counter and flags.
//   Reset clears the decode state to frame start and empties the output
//   stage. Bytes emitted before an error must be discarded by the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cobs_frame_decoder_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire cfd_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output cfd_pkg::out_t       out_data_o
);

  logic [7:0]  block_left_q, block_left_d;
  logic        prev_full_q, prev_full_d;
  logic        at_start_q, at_start_d;
  logic        error_q, error_d;
  logic [15:0] count_q, count_d;

  logic          out_valid_q, skid_valid_q;
  cfd_pkg::out_t out_q, skid_q;

  logic          in_fire, out_take, res_valid, has, last;
  logic [7:0]    ob;
  cfd_pkg::out_t res;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i & ~skid_valid_q;
  assign out_take   = out_valid_q & ~out_stall_i;
  assign last       = in_data_i.end_of_frame;

  always_comb begin
    block_left_d = block_left_q;
    prev_full_d  = prev_full_q;
    at_start_d   = at_start_q;
    error_d      = error_q;
    count_d      = count_q;
    has          = 1'b0;
    ob           = 8'd0;
    if (!error_q) begin
      if (in_data_i.in_byte == 8'd0) begin
        error_d = 1'b1;
      end else if (block_left_q == 8'd0) begin
        if (!at_start_q && !prev_full_q) begin
          has = 1'b1;
        end
        block_left_d = in_data_i.in_byte - 8'd1;
        prev_full_d  = (in_data_i.in_byte == cfd_pkg::FullCode);
        at_start_d   = 1'b0;
      end else begin
        has          = 1'b1;
        ob           = in_data_i.in_byte;
        block_left_d = block_left_q - 8'd1;
      end
      if (has && count_q != cfd_pkg::MaxCount) begin
        count_d = count_q + 16'd1;
      end
      if (last && block_left_d != 8'd0) begin
        error_d = 1'b1;
      end
    end

    res.out_byte       = ob;
    res.has_byte       = has;
    res.frame_error    = last & error_d;
    res.frame_last     = last;
    res.decoded_length = (last && !error_d) ? count_d : 16'd0;
    res_valid          = in_fire & (has | last);

    if (last) begin
      block_left_d = 8'd0;
      prev_full_d  = 1'b0;
      at_start_d   = 1'b1;
      error_d      = 1'b0;
      count_d      = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_left_q <= 8'd0;
      prev_full_q  <= 1'b0;
      at_start_q   <= 1'b1;
      error_q      <= 1'b0;
      count_q      <= 16'd0;
    end else if (in_fire) begin
      block_left_q <= block_left_d;
      prev_full_q  <= prev_full_d;
      at_start_q   <= at_start_d;
      error_q      <= error_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_block_not_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (block_left_q != 8'd0) |-> !at_start_q)
    else $error("open block at frame start");

  a_error_reporting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_error) |->
      (out_data_o.frame_last && out_data_o.decoded_length == 16'd0))
    else $error("frame error reported without last flag or with length");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.end_of_frame) |=>
      (at_start_q && !error_q && block_left_q == 8'd0 && count_q == 16'd0))
    else $error("decode state not cleared after end of frame");
`endif

endmodule

`default_nettype wire
